// ===== src/egx_pkg.sv =====
// Shared types, constants and the exp2 fraction table for the ExpGaussExp evaluator.
package egx_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int CFG_W           = 16;
  localparam int DENS_W          = 17;
  localparam int T_W             = 20;
  localparam int E2_W            = 36;
  localparam int PART_W          = 18;
  localparam int LOG2E_W         = 25;
  localparam int PROD_W          = PART_W + LOG2E_W;
  localparam int Y_W             = E2_W + LOG2E_W;
  localparam int FRAC_BITS       = 49;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int SHIFT_W         = 5;

  localparam logic [T_W-1:0]     T_POS_MAX = 20'd524287;
  localparam logic [T_W-1:0]     T_NEG_MAX = 20'd524288;
  localparam logic [LOG2E_W-1:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [63:0]        LN2_Q32   = 64'd2977044472;

  typedef enum logic [2:0] {
    REG_CENTER          = 3'd0,
    REG_INV_WIDTH_LEFT  = 3'd1,
    REG_INV_WIDTH_RIGHT = 3'd2,
    REG_TAIL_LEFT       = 3'd3,
    REG_TAIL_RIGHT      = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_CORE  = 2'd1,
    REGION_RIGHT = 2'd2
  } region_t;

  // Integer and fraction parts of E*log2(e), as needed by the exp2 unit
  typedef struct packed {
    logic               big;    // integer part >= 32, result underflows
    logic [SHIFT_W-1:0] shift;  // integer part when not big
    logic [IDX_W-1:0]   idx;    // top bits of the fraction
  } exp2_arg_t;

  typedef logic [DENS_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // round(2^(-k/depth) * 2^16) via a Taylor series to order 24 in Q.32
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] g;
    logic [63:0] term;
    logic [63:0] acc_pos;
    logic [63:0] acc_neg;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      g       = (64'(k) * LN2_Q32) / EXP_TABLE_DEPTH;
      term    = 64'd1 << 32;
      acc_pos = term;
      acc_neg = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * g) >> 32) / 64'(n);
        if (n % 2 == 1) begin
          acc_neg = acc_neg + term;
        end else begin
          acc_pos = acc_pos + term;
        end
      end
      tab[k] = DENS_W'(((acc_pos - acc_neg) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_table();

endpackage

// ===== src/egx_exp2.sv =====
// Base-2 power: fraction table lookup, then rounded right shift by the integer part; zero when big.
module egx_exp2
  import egx_pkg::*;
(
  input  exp2_arg_t         arg,
  output logic [DENS_W-1:0] density
);

  logic [DENS_W-1:0] entry;
  logic [31:0]       rounded;

  always_comb begin
    entry   = EXP_TAB[arg.idx];
    rounded = {{(32-DENS_W){1'b0}}, entry} + (32'd1 << (arg.shift - SHIFT_W'(1)));
    if (arg.big) begin
      density = '0;
    end else if (arg.shift == '0) begin
      density = entry;
    end else begin
      density = DENS_W'(rounded >> arg.shift);
    end
  end

endmodule

// ===== src/exp_gauss_exp_shape_eval_core.sv =====
// ExpGaussExp lineshape evaluator: seven-stage pipeline from sample to density.
// Throughput: one sample per cycle; each stage holds its item while the next is full,
// so stalls back up stage by stage and bubbles are squeezed out.
// The split 36x25 multiply for E*log2(e) takes two of the seven stages.
// Reset clears all stage valids and loads the register defaults.
module exp_gauss_exp_shape_eval_core
  import egx_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] sample
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [16:0] density, rest zero
  output logic [2:0]          m_axis_tuser,   // [1:0] region, [2] clipped
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // ---------------- configuration ----------------
  logic signed [CFG_W-1:0] center;
  logic [CFG_W-1:0]        inv_width_left;
  logic [CFG_W-1:0]        inv_width_right;
  logic [CFG_W-1:0]        tail_left;
  logic [CFG_W-1:0]        tail_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center          <= '0;
      inv_width_left  <= 16'd256;
      inv_width_right <= 16'd256;
      tail_left       <= 16'd4096;
      tail_right      <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER:          center          <= cfg_data;
        REG_INV_WIDTH_LEFT:  inv_width_left  <= cfg_data;
        REG_INV_WIDTH_RIGHT: inv_width_right <= cfg_data;
        REG_TAIL_LEFT:       tail_left       <= cfg_data;
        REG_TAIL_RIGHT:      tail_right      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  localparam int NSTG = 7;

  logic [NSTG:1] v;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---------------- stage 1: deviation magnitude ----------------
  logic signed [SAMPLE_W:0] dev;
  logic                     neg1;
  logic [SAMPLE_W-1:0]      mag1;

  assign dev = {s_axis_tdata[SAMPLE_W-1], s_axis_tdata} - {center[SAMPLE_W-1], center};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1 <= dev[SAMPLE_W];
      mag1 <= dev[SAMPLE_W] ? SAMPLE_W'(-dev) : SAMPLE_W'(dev);
    end
  end

  // ---------------- stage 2: t = |d| * inv, rounded and clamped ----------------
  logic [31:0]    scaled;
  logic [32:0]    scaled_rnd;
  logic [24:0]    t_raw;
  logic           t_over;
  logic           neg2;
  logic           sat2;
  logic [T_W-1:0] tm2;

  always_comb begin
    scaled     = 32'(mag1) * 32'(neg1 ? inv_width_left : inv_width_right);
    scaled_rnd = {1'b0, scaled} + 33'd128;
    t_raw      = scaled_rnd[32:8];
    t_over     = neg1 ? (t_raw > 25'(T_NEG_MAX)) : (t_raw > 25'(T_POS_MAX));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2 <= neg1;
      sat2 <= t_over;
      tm2  <= t_over ? (neg1 ? T_NEG_MAX : T_POS_MAX) : t_raw[T_W-1:0];
    end
  end

  // ---------------- stage 3: region and exponent products ----------------
  logic [CFG_W-1:0] alpha;
  region_t          region_c;
  region_t          region3;
  logic             sat3;
  logic [E2_W-1:0]  p_at3;
  logic [31:0]      p_aa3;
  logic [31:0]      p_tt3;

  always_comb begin
    alpha = neg2 ? tail_left : tail_right;
    if (neg2 && tm2 > T_W'(tail_left)) begin
      region_c = REGION_LEFT;
    end else if (!neg2 && tm2 > T_W'(tail_right)) begin
      region_c = REGION_RIGHT;
    end else begin
      region_c = REGION_CORE;
    end
  end

  // in the core t never exceeds the 16-bit alpha, so its low 16 bits are enough
  always_ff @(posedge clk) begin
    if (en[3]) begin
      region3 <= region_c;
      sat3    <= sat2;
      p_at3   <= E2_W'(alpha) * E2_W'(tm2);
      p_aa3   <= 32'(alpha) * 32'(alpha);
      p_tt3   <= 32'(tm2[15:0]) * 32'(tm2[15:0]);
    end
  end

  // ---------------- stage 4: 2E in Q.24 ----------------
  logic [E2_W:0]   tail_e2;
  region_t         region4;
  logic            sat4;
  logic [E2_W-1:0] e2_4;

  assign tail_e2 = {p_at3, 1'b0} - {{(E2_W-31){1'b0}}, p_aa3};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      region4 <= region3;
      sat4    <= sat3;
      e2_4    <= (region3 == REGION_CORE) ? E2_W'(p_tt3) : tail_e2[E2_W-1:0];
    end
  end

  // ---------------- stage 5: partial products of 2E * log2(e) ----------------
  region_t           region5;
  logic              sat5;
  logic [PROD_W-1:0] ph5;
  logic [PROD_W-1:0] pl5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      region5 <= region4;
      sat5    <= sat4;
      ph5     <= PROD_W'(e2_4[E2_W-1:PART_W]) * PROD_W'(LOG2E_Q24);
      pl5     <= PROD_W'(e2_4[PART_W-1:0]) * PROD_W'(LOG2E_Q24);
    end
  end

  // ---------------- stage 6: integer and fraction split ----------------
  logic [Y_W-1:0] y;
  region_t        region6;
  logic           sat6;
  exp2_arg_t      arg6;

  assign y = {ph5, {PART_W{1'b0}}} + {{PART_W{1'b0}}, pl5};

  always_ff @(posedge clk) begin
    if (en[6]) begin
      region6    <= region5;
      sat6       <= sat5;
      arg6.big   <= |y[Y_W-1:FRAC_BITS+SHIFT_W];
      arg6.shift <= y[FRAC_BITS+SHIFT_W-1:FRAC_BITS];
      arg6.idx   <= y[FRAC_BITS-1 -: IDX_W];
    end
  end

  // ---------------- stage 7: exp2 and output register ----------------
  logic [DENS_W-1:0] dens_c;
  logic [DENS_W-1:0] density;
  region_t           region7;
  logic              clipped;

  egx_exp2 u_exp2 (
    .arg     (arg6),
    .density (dens_c)
  );

  always_ff @(posedge clk) begin
    if (en[7]) begin
      density <= dens_c;
      region7 <= region6;
      clipped <= sat6 || (dens_c == '0);
    end
  end

  assign m_axis_tvalid = v[NSTG];
  assign m_axis_tdata  = {{(24-DENS_W){1'b0}}, density};
  assign m_axis_tuser  = {clipped, region7};

endmodule
